// ===== src/mftc_pkg.sv =====
// Shared types and constants for the MIDI filter, transpose and clock unit.
`default_nettype none

package mftc_pkg;

	localparam int MACROS_DEFAULT = 8;
	localparam int MACROS_MAX     = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 56;
	localparam int PHASE_W     = 26;

	localparam logic [23:0] PERIOD_RESET = 24'd235200;
	localparam logic [55:0] CC_MAP_RESET = 56'd15314863436171924;
	localparam logic [PHASE_W-1:0] ONE_SAMPLE = 26'd256;

	localparam logic [7:0] ST_CLOCK = 8'hF8;
	localparam logic [7:0] ST_START = 8'hFA;
	localparam logic [7:0] ST_STOP  = 8'hFC;
	localparam logic [7:0] ST_CHAN_LO = 8'h80;
	localparam logic [7:0] ST_CHAN_HI = 8'hEF;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_CC       = 4'hB;

	typedef enum logic [1:0] {
		FUNC_MSG       = 2'd0,
		FUNC_TICK      = 2'd1,
		FUNC_TRANSPORT = 2'd2,
		FUNC_QUERY     = 2'd3
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CHANNEL_FILTER   = 3'd0,
		CFG_TRANSPOSE_AMOUNT = 3'd1,
		CFG_CLOCK_IN_ENABLE  = 3'd2,
		CFG_CLOCK_OUT_ENABLE = 3'd3,
		CFG_CLOCK_PERIOD     = 3'd4,
		CFG_MACRO_CC_MAP     = 3'd5
	} cfg_index_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] status_byte;
		logic [6:0] data_one;
		logic [6:0] data_two;
		logic       playing;
	} in_t;

	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_status;
		logic [6:0]  out_data_one;
		logic [6:0]  out_data_two;
		logic [7:0]  macro_hit_mask;
		logic [6:0]  macro_value;
		logic [31:0] ext_clock_count;
	} out_t;

	typedef struct packed {
		logic [4:0]        channel_filter;
		logic signed [5:0] transpose_amount;
		logic              clock_in_enable;
		logic              clock_out_enable;
		logic [23:0]       clock_period;
		logic [55:0]       macro_cc_map;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/midi_filter_transpose_clock_unit.sv =====
// Each result word is written into the two-entry result buffer when its input word is accepted.
// Throughput: one word per cycle; processing is a single combinational pass that
// updates state at acceptance, followed by a two-entry result buffer.
// Input stalls only while both buffer entries hold results not yet taken.
// Reset (arst_n low, asynchronous): registers return to defaults, transport
// stopped, phase, clock count and macro slots cleared, result buffer empty.
`default_nettype none

module midi_filter_transpose_clock_unit #(
	parameter int NUM_MACROS = mftc_pkg::MACROS_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mftc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mftc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire mftc_pkg::in_t                    in_item,
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output mftc_pkg::out_t                        res_item
);
	import mftc_pkg::*;

	cfg_t cfg;
	out_t result;
	logic accept;

	assign accept = in_valid && in_ready;

	mftc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mftc_proc #(
		.NUM_MACROS (NUM_MACROS)
	) u_proc (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.cfg    (cfg),
		.result (result)
	);

	mftc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (result),
		.can_push  (in_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

// ===== src/mftc_cfg.sv =====
// Configuration register file written through the plain write port.
`default_nettype none

module mftc_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mftc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mftc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output mftc_pkg::cfg_t                       cfg
);
	import mftc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_filter   <= '0;
			cfg_q.transpose_amount <= '0;
			cfg_q.clock_in_enable  <= 1'b0;
			cfg_q.clock_out_enable <= 1'b0;
			cfg_q.clock_period     <= PERIOD_RESET;
			cfg_q.macro_cc_map     <= CC_MAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHANNEL_FILTER:   cfg_q.channel_filter   <= cfg_wdata[4:0];
				CFG_TRANSPOSE_AMOUNT: cfg_q.transpose_amount <= $signed(cfg_wdata[5:0]);
				CFG_CLOCK_IN_ENABLE:  cfg_q.clock_in_enable  <= cfg_wdata[0];
				CFG_CLOCK_OUT_ENABLE: cfg_q.clock_out_enable <= cfg_wdata[0];
				CFG_CLOCK_PERIOD:     cfg_q.clock_period     <= cfg_wdata[23:0];
				CFG_MACRO_CC_MAP:     cfg_q.macro_cc_map     <= cfg_wdata[55:0];
				default: begin
					// writes past the last register are ignored
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/mftc_proc.sv =====
// Per-word processing: filter, transpose, macro capture, clock counting and generation.
`default_nettype none

module mftc_proc #(
	parameter int NUM_MACROS = mftc_pkg::MACROS_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire mftc_pkg::in_t   item,
	input  wire mftc_pkg::cfg_t  cfg,
	output mftc_pkg::out_t       result
);
	import mftc_pkg::*;

	logic               running_q;
	logic [PHASE_W-1:0] phase_q;
	logic [31:0]        clocks_q;
	logic [6:0]         macro_q [NUM_MACROS];

	logic               chan_msg;
	logic [4:0]         chan_num;
	logic               drop;
	logic [3:0]         kind;
	logic               note_on;
	logic               note_off;
	logic signed [8:0]  note_sum;
	logic [6:0]         note_clamped;
	logic               is_cc;
	logic [7:0]         hit_mask;
	logic [6:0]         query_value;
	logic               count_clock;
	logic               tick_active;
	logic               tick_fire;
	logic [PHASE_W-1:0] phase_pre;
	logic [PHASE_W-1:0] phase_tick;

	logic               running_d;
	logic [PHASE_W-1:0] phase_d;
	logic [31:0]        clocks_d;
	logic               capture;

	always_comb begin
		chan_msg = (item.status_byte >= ST_CHAN_LO) && (item.status_byte <= ST_CHAN_HI);
		chan_num = {1'b0, item.status_byte[3:0]} + 5'd1;
		drop     = (cfg.channel_filter != 5'd0) && chan_msg && (chan_num != cfg.channel_filter);
		kind     = item.status_byte[7:4];
		note_on  = chan_msg && (kind == KIND_NOTE_ON) && (item.data_two != 7'd0);
		note_off = chan_msg && ((kind == KIND_NOTE_OFF) ||
			((kind == KIND_NOTE_ON) && (item.data_two == 7'd0)));
		is_cc    = chan_msg && (kind == KIND_CC);

		note_sum = $signed({2'b00, item.data_one}) +
			$signed({{3{cfg.transpose_amount[5]}}, cfg.transpose_amount});
		// clamp to 0..127
		if (note_sum[8]) begin
			note_clamped = 7'd0;
		end else if (note_sum[7]) begin
			note_clamped = 7'd127;
		end else begin
			note_clamped = note_sum[6:0];
		end

		count_clock = cfg.clock_in_enable && (item.status_byte == ST_CLOCK);

		tick_active = cfg.clock_out_enable && running_q;
		tick_fire   = phase_q < ONE_SAMPLE;
		phase_pre   = tick_fire ? phase_q + PHASE_W'(cfg.clock_period) : phase_q;
		// floor at zero when the phase plus the period is below one sample
		phase_tick  = (phase_pre >= ONE_SAMPLE) ? phase_pre - ONE_SAMPLE : '0;
	end

	always_comb begin
		hit_mask    = '0;
		query_value = '0;
		for (int i = 0; i < NUM_MACROS; i++) begin
			if (cfg.macro_cc_map[7*i +: 7] == item.data_one) begin
				hit_mask[i] = 1'b1;
			end
			if (item.data_one[2:0] == 3'(i)) begin
				query_value = macro_q[i];
			end
		end
	end

	always_comb begin
		running_d = running_q;
		phase_d   = phase_q;
		clocks_d  = clocks_q;
		capture   = 1'b0;
		result    = '0;
		unique case (item.func)
			FUNC_MSG: begin
				if (count_clock) begin
					clocks_d = clocks_q + 32'd1;
				end
				if (!drop) begin
					result.out_valid    = 1'b1;
					result.out_status   = item.status_byte;
					result.out_data_one = item.data_one;
					result.out_data_two = item.data_two;
					if ((cfg.transpose_amount != 6'sd0) && (note_on || note_off)) begin
						result.out_data_one = note_clamped;
						result.out_status   = {note_on ? KIND_NOTE_ON : KIND_NOTE_OFF,
							item.status_byte[3:0]};
					end
					if (is_cc) begin
						capture               = 1'b1;
						result.macro_hit_mask = hit_mask;
					end
				end
			end
			FUNC_TICK: begin
				if (tick_active) begin
					phase_d = phase_tick;
					if (tick_fire) begin
						result.out_valid  = 1'b1;
						result.out_status = ST_CLOCK;
					end
				end
			end
			FUNC_TRANSPORT: begin
				if (item.playing != running_q) begin
					running_d         = item.playing;
					phase_d           = '0;
					result.out_valid  = 1'b1;
					result.out_status = item.playing ? ST_START : ST_STOP;
				end
			end
			FUNC_QUERY: begin
				result.macro_value = query_value;
			end
		endcase
		result.ext_clock_count = clocks_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= '0;
			clocks_q  <= '0;
		end else if (accept) begin
			running_q <= running_d;
			phase_q   <= phase_d;
			clocks_q  <= clocks_d;
		end
	end

	for (genvar g = 0; g < NUM_MACROS; g++) begin : g_slot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				macro_q[g] <= '0;
			end else if (accept && capture && hit_mask[g]) begin
				macro_q[g] <= item.data_two;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/mftc_outbuf.sv =====
// Two-entry result buffer between the processing logic and the output channel.
`default_nettype none

module mftc_outbuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mftc_pkg::out_t push_word,
	output logic                can_push,
	output logic                res_valid,
	input  wire logic           res_ready,
	output mftc_pkg::out_t      res_item
);
	import mftc_pkg::*;

	out_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign can_push  = count_q != 2'd2;
	assign res_valid = count_q != 2'd0;
	assign res_item  = ent_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/mftc_checker.sv =====
// Port-level checks for the MIDI filter, transpose and clock unit, with bind.
`default_nettype none

module mftc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire mftc_pkg::out_t res_item
);
	import mftc_pkg::*;

	// a waiting result word stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word withdrawn while stalled");

	// input only stalls behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid)
		else $error("input stalled with no result pending");

	// after an accepted word, a result word is offered in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> res_valid)
		else $error("accepted word produced no result word");

	// macro hits come only with an emitted control change
	a_hit_cc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.macro_hit_mask != 8'd0) |->
			res_item.out_valid && (res_item.out_status[7:4] == KIND_CC))
		else $error("macro hit without control change");

	// no message emitted means all message bytes are zero
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.out_valid |->
			(res_item.out_status == 8'd0) && (res_item.out_data_one == 7'd0) &&
			(res_item.out_data_two == 7'd0))
		else $error("message bytes set without out_valid");

endmodule

bind midi_filter_transpose_clock_unit mftc_checker u_mftc_checker (.*);

`default_nettype wire
